FILE: design/lbfd_pkg.sv
// ----------------------------------------------------------------------------
// lbfd_pkg: shared types and constants of the LED bar frame driver
// Field widths, level codes, request modes, sequencer states and the
// control bundles passed between the sequencer, level bank and shifter.
// ----------------------------------------------------------------------------
package lbfd_pkg;

   localparam int NUM_LEDS    = 10;
   localparam int WORD_W      = 16;
   localparam int LEVEL_W     = 8;
   localparam int IDX_W       = 4;
   localparam int MODE_W      = 2;
   localparam int FRAME_WORDS = NUM_LEDS + 3;
   localparam int WCNT_W      = $clog2(FRAME_WORDS);
   localparam int LED_AW      = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
   localparam int BITCNT_W    = $clog2(WORD_W);
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;

   localparam logic [CSR_AW-3:0] CSR_CMD_WORD = 1'b0;

   localparam logic [LEVEL_W-1:0] LVL_OFF  = 8'h00;
   localparam logic [LEVEL_W-1:0] LVL_MED  = 8'h0F;
   localparam logic [LEVEL_W-1:0] LVL_FULL = 8'hFF;

   localparam logic [MODE_W-1:0] MODE_SET_ONE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SET_ALL = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_LOAD,
      ST_SHIFT,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic               wr_en;
      logic               wr_all;
      logic [LED_AW-1:0]  wr_idx;
      logic [LEVEL_W-1:0] wr_level;
      logic [LED_AW-1:0]  rd_idx;
   } bank_ctrl_type;

   typedef struct packed {
      logic              load;
      logic [WORD_W-1:0] src;
   } shift_ctrl_type;

   function automatic logic level_valid(input logic [LEVEL_W-1:0] lv);
      return (lv == LVL_OFF) || (lv == LVL_MED) || (lv == LVL_FULL);
   endfunction

   function automatic logic [LEVEL_W-1:0] classify(input logic [LEVEL_W-1:0] lv);
      logic [LEVEL_W-1:0] r;
      if (lv == LVL_OFF) begin
         r = LVL_OFF;
      end else if (lv == LVL_MED) begin
         r = LVL_MED;
      end else begin
         r = LVL_FULL;
      end
      return r;
   endfunction

endpackage

FILE: design/lbfd_level_bank.sv
// ----------------------------------------------------------------------------
// lbfd_level_bank: stored LED brightness levels
// One level per LED, cleared by reset; single-LED or broadcast write and
// one read port.
// ----------------------------------------------------------------------------
module lbfd_level_bank
   import lbfd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  bank_ctrl_type      ctrl,
   output logic [LEVEL_W-1:0] rd_data
);

   logic [LEVEL_W-1:0] levels_ff [NUM_LEDS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEDS; i++) begin
            levels_ff[i] <= LVL_OFF;
         end
      end else if (ctrl.wr_all) begin
         for (int i = 0; i < NUM_LEDS; i++) begin
            levels_ff[i] <= ctrl.wr_level;
         end
      end else if (ctrl.wr_en && (32'(ctrl.wr_idx) < NUM_LEDS)) begin
         levels_ff[ctrl.wr_idx] <= ctrl.wr_level;
      end
   end

   assign rd_data = (32'(ctrl.rd_idx) < NUM_LEDS) ? levels_ff[ctrl.rd_idx] : LVL_OFF;

endmodule

FILE: design/lbfd_word_shift.sv
// ----------------------------------------------------------------------------
// lbfd_word_shift: bit-serial word shifter
// Moves a loaded word MSB first, one bit per cycle, into the result register,
// which then holds it until the next load.
// ----------------------------------------------------------------------------
module lbfd_word_shift
   import lbfd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  shift_ctrl_type    ctrl,
   output logic              busy,
   output logic [WORD_W-1:0] word
);

   logic [WORD_W-1:0]   src_ff, src_in;
   logic [WORD_W-1:0]   dst_ff, dst_in;
   logic [BITCNT_W-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;

   always_comb begin
      src_in  = src_ff;
      dst_in  = dst_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (ctrl.load) begin
         src_in  = ctrl.src;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // advance one bit, MSB first
         dst_in = {dst_ff[WORD_W-2:0], src_ff[WORD_W-1]};
         src_in = {src_ff[WORD_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == BITCNT_W'(WORD_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      src_ff <= src_in;
      dst_ff <= dst_in;
   end

   assign busy = busy_ff;
   assign word = dst_ff;

endmodule

FILE: design/lbfd_frame_seq.sv
// ----------------------------------------------------------------------------
// lbfd_frame_seq: request decoder and frame sequencer
// Checks each request, updates the level bank, and steps through the frame
// words, feeding each one to the shifter and presenting it as a result word.
// ----------------------------------------------------------------------------
module lbfd_frame_seq
   import lbfd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [MODE_W-1:0]  req_mode,
   input  logic [IDX_W-1:0]   req_led_index,
   input  logic [LEVEL_W-1:0] req_level,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_last,
   output logic               rsp_ok,
   output logic [LEVEL_W-1:0] rsp_read_level,
   input  logic [WORD_W-1:0]  command_word,
   input  logic [LEVEL_W-1:0] bank_rd_data,
   input  logic               shift_busy,
   output bank_ctrl_type      bank_ctrl,
   output shift_ctrl_type     shift_ctrl
);

   state_type          state_ff, state_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               ok_ff, ok_in;
   logic               frame_ff, frame_in;
   logic [LEVEL_W-1:0] rd_ff, rd_in;
   logic [WCNT_W-1:0]  wcnt_ff, wcnt_in;

   logic idx_ok;
   logic lvl_ok;
   logic last_word;

   assign idx_ok    = 32'(idx_ff) < NUM_LEDS;
   assign lvl_ok    = level_valid(level_ff);
   assign last_word = !frame_ff || (32'(wcnt_ff) == FRAME_WORDS - 1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_SHIFT;
         ST_SHIFT: begin
            if (!shift_busy) state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_ready) state_in = last_word ? ST_IDLE : ST_LOAD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      mode_in  = mode_ff;
      idx_in   = idx_ff;
      level_in = level_ff;
      ok_in    = ok_ff;
      frame_in = frame_ff;
      rd_in    = rd_ff;
      wcnt_in  = wcnt_ff;

      req_ready = 1'b0;
      rsp_valid = 1'b0;

      bank_ctrl.wr_en    = 1'b0;
      bank_ctrl.wr_all   = 1'b0;
      bank_ctrl.wr_idx   = LED_AW'(idx_ff);
      bank_ctrl.wr_level = level_ff;
      bank_ctrl.rd_idx   = LED_AW'(wcnt_ff - 1'b1);

      shift_ctrl.load = 1'b0;
      shift_ctrl.src  = '0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mode_in  = req_mode;
               idx_in   = req_led_index;
               level_in = req_level;
            end
         end
         ST_DECODE: begin
            bank_ctrl.rd_idx = LED_AW'(idx_ff);
            wcnt_in  = '0;
            rd_in    = LVL_OFF;
            ok_in    = 1'b0;
            frame_in = 1'b0;
            case (mode_ff)
               MODE_SET_ONE: begin
                  ok_in           = idx_ok && lvl_ok;
                  frame_in        = idx_ok && lvl_ok;
                  bank_ctrl.wr_en = idx_ok && lvl_ok;
               end
               MODE_SET_ALL: begin
                  ok_in            = lvl_ok;
                  frame_in         = lvl_ok;
                  bank_ctrl.wr_all = lvl_ok;
               end
               MODE_READ: begin
                  ok_in = idx_ok;
                  if (idx_ok) rd_in = classify(bank_rd_data);
               end
               default: begin
                  ok_in = 1'b0;
               end
            endcase
         end
         ST_LOAD: begin
            shift_ctrl.load = 1'b1;
            if (!frame_ff) begin
               shift_ctrl.src = '0;
            end else if (wcnt_ff == '0) begin
               shift_ctrl.src = command_word;
            end else if (32'(wcnt_ff) <= NUM_LEDS) begin
               shift_ctrl.src = WORD_W'(bank_rd_data);
            end else begin
               shift_ctrl.src = '0;
            end
         end
         ST_SHIFT: begin
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready && !last_word) wcnt_in = wcnt_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         wcnt_ff  <= wcnt_in;
      end
      mode_ff  <= mode_in;
      idx_ff   <= idx_in;
      level_ff <= level_in;
      ok_ff    <= ok_in;
      frame_ff <= frame_in;
      rd_ff    <= rd_in;
   end

   assign rsp_last       = last_word;
   assign rsp_ok         = ok_ff;
   assign rsp_read_level = rd_ff;

endmodule

FILE: design/led_bar_frame_driver.sv
// Every result word passes through the bit-serial word shifter; the next frame
// word is loaded only after the previous one is taken. A frame holds 13 words
// (the command word, the ten LED levels and two zero words), while a read or
// rejected request gets a single-word reply.
// One request is handled at a time; a new one is taken once the last word goes.
// Reset (synchronous, active high) clears all LED levels and the command word.
// ----------------------------------------------------------------------------
// led_bar_frame_driver: ten-LED bar frame driver
// Keeps LED brightness levels, builds update frames and answers level reads;
// the command word is written through the CSR port.
// ----------------------------------------------------------------------------
module led_bar_frame_driver
   import lbfd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [MODE_W-1:0]  req_mode,
   input  logic [IDX_W-1:0]   req_led_index,
   input  logic [LEVEL_W-1:0] req_level,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [WORD_W-1:0]  rsp_frame_word,
   output logic               rsp_last,
   output logic               rsp_ok,
   output logic [LEVEL_W-1:0] rsp_read_level,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [CSR_AW-1:0]  csr_paddr,
   input  logic [CSR_DW-1:0]  csr_pwdata,
   output logic [CSR_DW-1:0]  csr_prdata,
   output logic               csr_pready
);

   logic [WORD_W-1:0]  command_ff, command_in;
   logic               cmd_sel;
   logic [LEVEL_W-1:0] bank_rd_data;
   logic               shift_busy;
   bank_ctrl_type      bank_ctrl;
   shift_ctrl_type     shift_ctrl;

   assign cmd_sel    = csr_paddr[CSR_AW-1:2] == CSR_CMD_WORD;
   assign csr_pready = 1'b1;
   assign csr_prdata = cmd_sel ? CSR_DW'(command_ff) : '0;

   always_comb begin
      command_in = command_ff;
      if (csr_psel && csr_penable && csr_pwrite && cmd_sel) begin
         command_in = csr_pwdata[WORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         command_ff <= '0;
      end else begin
         command_ff <= command_in;
      end
   end

   lbfd_frame_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_led_index  (req_led_index),
      .req_level      (req_level),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_last       (rsp_last),
      .rsp_ok         (rsp_ok),
      .rsp_read_level (rsp_read_level),
      .command_word   (command_ff),
      .bank_rd_data   (bank_rd_data),
      .shift_busy     (shift_busy),
      .bank_ctrl      (bank_ctrl),
      .shift_ctrl     (shift_ctrl)
   );

   lbfd_level_bank u_bank (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (bank_ctrl),
      .rd_data (bank_rd_data)
   );

   lbfd_word_shift u_shift (
      .clock (clock),
      .reset (reset),
      .ctrl  (shift_ctrl),
      .busy  (shift_busy),
      .word  (rsp_frame_word)
   );

endmodule

FILE: design/lbfd_checker.sv
// ----------------------------------------------------------------------------
// lbfd_checker: port-level checks of the LED bar frame driver
// Watches the request and result channels and checks framing rules.
// ----------------------------------------------------------------------------
module lbfd_checker
   import lbfd_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [WORD_W-1:0]  rsp_frame_word,
   input logic               rsp_last,
   input logic               rsp_ok,
   input logic [LEVEL_W-1:0] rsp_read_level
);

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_word)
         && $stable(rsp_last) && $stable(rsp_ok) && $stable(rsp_read_level))
      else $error("result word changed while stalled");

   // one request in flight: no new request while a result is shown
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a result is pending");

   // an accepted request never answers in the next cycle
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid && !req_ready)
      else $error("result or ready right after request accept");

   // a rejected request ends at once with an empty word
   a_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_last && (rsp_frame_word == '0)
         && (rsp_read_level == '0))
      else $error("rejected request gave a non-empty result");

   // a read level only comes with a single accepted word
   a_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_read_level != '0) |-> rsp_ok && rsp_last
         && (rsp_frame_word == '0))
      else $error("read level outside a read result");

endmodule

bind led_bar_frame_driver lbfd_checker u_lbfd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_frame_word (rsp_frame_word),
   .rsp_last       (rsp_last),
   .rsp_ok         (rsp_ok),
   .rsp_read_level (rsp_read_level)
);
